// ===== src/hash_table_overflow_area_core_assert.svh =====
// Assertion macros for the hash table core checker.
`ifndef HASH_TABLE_OVERFLOW_AREA_CORE_ASSERT_SVH
`define HASH_TABLE_OVERFLOW_AREA_CORE_ASSERT_SVH

// Same-cycle implication, masked during reset.
`define HTOA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, masked during reset.
`define HTOA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication, always live (used for reset behavior).
`define HTOA_ASSERT_NEXT_LIVE(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/htoa_pkg.sv =====
package htoa_pkg;

   localparam int HOME_SLOTS     = 7;
   localparam int OVERFLOW_SLOTS = 2;
   localparam int TOTAL_SLOTS    = HOME_SLOTS + OVERFLOW_SLOTS;

   localparam int OP_W       = 2;
   localparam int KEY_W      = 31;
   localparam int PAYLOAD_W  = 64;
   localparam int STATUS_W   = 3;
   localparam int SLOT_IDX_W = 4;

   localparam int SLOT_W  = $clog2(TOTAL_SLOTS);
   localparam int HOME_W  = (HOME_SLOTS > 1) ? $clog2(HOME_SLOTS) : 1;
   localparam int OVF_W   = (OVERFLOW_SLOTS > 1) ? $clog2(OVERFLOW_SLOTS) : 1;
   localparam int NFO_W   = $clog2(OVERFLOW_SLOTS + 1);
   localparam int ENTRY_W = KEY_W + PAYLOAD_W;

   // key % HOME_SLOTS via exact reciprocal: q = (key * m) >> (KEY_W + l)
   localparam int HASH_L     = $clog2(HOME_SLOTS);
   localparam int HASH_SHIFT = KEY_W + HASH_L;
   localparam int RECIP_W    = KEY_W + 1;
   localparam int PROD_W     = KEY_W + RECIP_W;
   localparam logic [63:0] HASH_RECIP =
      ((64'd1 << HASH_SHIFT) + 64'(HOME_SLOTS) - 64'd1) / 64'(HOME_SLOTS);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 2'd0,
      OP_SEARCH = 2'd1,
      OP_REMOVE = 2'd2
   } htoa_op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_INS_HOME = 3'd0,
      ST_INS_OVF  = 3'd1,
      ST_FULL     = 3'd2,
      ST_FOUND    = 3'd3,
      ST_MISS     = 3'd4,
      ST_REMOVED  = 3'd5
   } htoa_status_type;

   typedef struct packed {
      logic [OP_W-1:0]      op;
      logic [KEY_W-1:0]     key;
      logic [PAYLOAD_W-1:0] payload;
      logic [HOME_W-1:0]    home;
   } htoa_cmd_type;

   typedef struct packed {
      htoa_status_type       status;
      logic [SLOT_IDX_W-1:0] slot_index;
      logic [PAYLOAD_W-1:0]  found_payload;
   } htoa_rsp_type;

endpackage

// ===== src/htoa_if.sv =====
interface htoa_req_if
   import htoa_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic [OP_W-1:0]      op;
   logic [KEY_W-1:0]     record_key;
   logic [PAYLOAD_W-1:0] record_payload;

   modport source (output valid, op, record_key, record_payload, input ready);
   modport sink   (input valid, op, record_key, record_payload, output ready);
endinterface

interface htoa_rsp_if
   import htoa_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic [STATUS_W-1:0]   status;
   logic [SLOT_IDX_W-1:0] slot_index;
   logic [PAYLOAD_W-1:0]  found_payload;

   modport source (output valid, status, slot_index, found_payload, input ready);
   modport sink   (input valid, status, slot_index, found_payload, output ready);
endinterface

// ===== src/htoa_ram.sv =====
module htoa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd0_addr,
   output logic [WIDTH-1:0]         rd0_data,
   input  logic [$clog2(DEPTH)-1:0] rd1_addr,
   output logic [WIDTH-1:0]         rd1_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd0_data <= mem_ff[rd0_addr];
      rd1_data <= mem_ff[rd1_addr];
   end

endmodule

// ===== src/htoa_front.sv =====
module htoa_front
   import htoa_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   htoa_req_if.sink     req_ch,
   output logic         out_valid,
   input  logic         out_ready,
   output htoa_cmd_type out_cmd
);

   logic                 s1_valid_ff, s1_valid_in;
   logic [OP_W-1:0]      s1_op_ff;
   logic [KEY_W-1:0]     s1_key_ff;
   logic [PAYLOAD_W-1:0] s1_payload_ff;
   logic [PROD_W-1:0]    s1_prod_ff, s1_prod_in;
   logic                 s2_valid_ff, s2_valid_in;
   htoa_cmd_type         s2_cmd_ff, s2_cmd_in;

   logic                 s1_adv, s2_adv;
   logic [RECIP_W-1:0]   recip;
   logic [KEY_W-1:0]     quot, quot_mul;

   assign s2_adv       = !s2_valid_ff || out_ready;
   assign s1_adv       = !s1_valid_ff || s2_adv;
   assign req_ch.ready = s1_adv;

   // stage 1: key times reciprocal
   assign recip      = RECIP_W'(HASH_RECIP);
   assign s1_prod_in = PROD_W'(req_ch.record_key) * PROD_W'(recip);
   assign s1_valid_in = s1_adv ? req_ch.valid : s1_valid_ff;

   // stage 2: remainder = key - quotient * HOME_SLOTS
   assign quot     = KEY_W'(s1_prod_ff >> HASH_SHIFT);
   assign quot_mul = KEY_W'(quot * KEY_W'(HOME_SLOTS));

   always_comb begin
      s2_cmd_in.op      = s1_op_ff;
      s2_cmd_in.key     = s1_key_ff;
      s2_cmd_in.payload = s1_payload_ff;
      s2_cmd_in.home    = HOME_W'(s1_key_ff - quot_mul);
   end

   assign s2_valid_in = s2_adv ? s1_valid_ff : s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s1_op_ff      <= req_ch.op;
         s1_key_ff     <= req_ch.record_key;
         s1_payload_ff <= req_ch.record_payload;
         s1_prod_ff    <= s1_prod_in;
      end
      if (s2_adv) begin
         s2_cmd_ff <= s2_cmd_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_cmd   = s2_cmd_ff;

endmodule

// ===== src/htoa_queue.sv =====
module htoa_queue
   import htoa_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  htoa_cmd_type in_cmd,
   output logic         out_valid,
   input  logic         out_ready,
   output htoa_cmd_type out_cmd
);

   htoa_cmd_type      entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              push, pop;

   function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
      return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
   endfunction

   assign in_ready  = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_cmd   = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   assign wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
   assign rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_cmd;
      end
   end

endmodule

// ===== src/htoa_back.sv =====
module htoa_back
   import htoa_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  htoa_cmd_type in_cmd,
   htoa_rsp_if.source   rsp_ch
);

   typedef enum logic [1:0] {
      S_ISSUE = 2'b01,
      S_EXEC  = 2'b10
   } htoa_state_type;

   htoa_state_type    state_ff, state_in;
   htoa_cmd_type      cmd_ff, cmd_in;
   logic              slot_valid_ff [TOTAL_SLOTS];
   logic              slot_valid_in [TOTAL_SLOTS];
   logic              link_valid_ff [HOME_SLOTS];
   logic              link_valid_in [HOME_SLOTS];
   logic [OVF_W-1:0]  link_idx_ff [HOME_SLOTS];
   logic [OVF_W-1:0]  link_idx_in [HOME_SLOTS];
   logic [NFO_W-1:0]  nfo_ff, nfo_in;
   logic              rsp_valid_ff, rsp_valid_in;
   htoa_rsp_type      rsp_ff, rsp_in;

   logic              wr_en;
   logic [SLOT_W-1:0] wr_addr;
   logic [ENTRY_W-1:0] wr_data;
   logic [HOME_W-1:0] rd_home_idx;
   logic [SLOT_W-1:0] rd0_addr, rd1_addr;
   logic [ENTRY_W-1:0] rd_home, rd_ovf;

   logic [SLOT_W-1:0] home_abs, ov_abs, nfo_abs;
   logic [OVF_W-1:0]  ov_link;
   logic              home_taken, ov_hit, home_hit, has_room;

   // slot entries: {key, payload}, read at home and at linked overflow slot
   htoa_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TOTAL_SLOTS)
   ) u_slots (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd0_addr (rd0_addr),
      .rd0_data (rd_home),
      .rd1_addr (rd1_addr),
      .rd1_data (rd_ovf)
   );

   // keep reading for the current request while its response is stalled
   assign rd_home_idx = (state_ff == S_ISSUE) ? in_cmd.home : cmd_ff.home;
   assign rd0_addr    = SLOT_W'(rd_home_idx);
   assign rd1_addr    = SLOT_W'(HOME_SLOTS) + SLOT_W'(link_idx_ff[rd_home_idx]);

   assign home_abs   = SLOT_W'(cmd_ff.home);
   assign ov_link    = link_idx_ff[cmd_ff.home];
   assign ov_abs     = SLOT_W'(HOME_SLOTS) + SLOT_W'(ov_link);
   assign nfo_abs    = SLOT_W'(HOME_SLOTS) + SLOT_W'(nfo_ff);
   assign home_taken = slot_valid_ff[home_abs];
   assign has_room   = (nfo_ff < NFO_W'(OVERFLOW_SLOTS));
   assign ov_hit     = link_valid_ff[cmd_ff.home]
                    && (NFO_W'(ov_link) < NFO_W'(OVERFLOW_SLOTS))
                    && slot_valid_ff[ov_abs]
                    && (rd_ovf[ENTRY_W-1:PAYLOAD_W] == cmd_ff.key);
   assign home_hit   = !ov_hit && home_taken
                    && (rd_home[ENTRY_W-1:PAYLOAD_W] == cmd_ff.key);

   assign wr_data  = {cmd_ff.key, cmd_ff.payload};

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      slot_valid_in = slot_valid_ff;
      link_valid_in = link_valid_ff;
      link_idx_in   = link_idx_ff;
      nfo_in        = nfo_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_in        = rsp_ff;
      wr_en         = 1'b0;
      wr_addr       = home_abs;
      in_ready      = 1'b0;

      unique case (state_ff)
         S_ISSUE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               cmd_in   = in_cmd;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               state_in             = S_ISSUE;
               rsp_valid_in         = 1'b1;
               rsp_in.found_payload = '0;
               rsp_in.slot_index    = SLOT_IDX_W'(home_abs);
               if (cmd_ff.op == OP_INSERT) begin
                  if (!home_taken) begin
                     wr_en                       = 1'b1;
                     slot_valid_in[home_abs]     = 1'b1;
                     link_valid_in[cmd_ff.home]  = 1'b0;
                     rsp_in.status               = ST_INS_HOME;
                  end else if (has_room) begin
                     // collision: next overflow slot, relink the home slot
                     wr_en                       = 1'b1;
                     wr_addr                     = nfo_abs;
                     slot_valid_in[nfo_abs]      = 1'b1;
                     link_valid_in[cmd_ff.home]  = 1'b1;
                     link_idx_in[cmd_ff.home]    = OVF_W'(nfo_ff);
                     nfo_in                      = nfo_ff + NFO_W'(1);
                     rsp_in.status               = ST_INS_OVF;
                     rsp_in.slot_index           = SLOT_IDX_W'(nfo_abs);
                  end else begin
                     rsp_in.status = ST_FULL;
                  end
               end else if (!ov_hit && !home_hit) begin
                  rsp_in.status = ST_MISS;
               end else begin
                  // overflow entry wins over home entry
                  rsp_in.slot_index    = ov_hit ? SLOT_IDX_W'(ov_abs)
                                                : SLOT_IDX_W'(home_abs);
                  rsp_in.found_payload = ov_hit ? rd_ovf[PAYLOAD_W-1:0]
                                                : rd_home[PAYLOAD_W-1:0];
                  if (cmd_ff.op == OP_REMOVE) begin
                     rsp_in.status = ST_REMOVED;
                     if (ov_hit) begin
                        slot_valid_in[ov_abs] = 1'b0;
                     end else begin
                        slot_valid_in[home_abs]    = 1'b0;
                        link_valid_in[cmd_ff.home] = 1'b0;
                     end
                  end else begin
                     rsp_in.status = ST_FOUND;
                  end
               end
            end
         end
         default: begin
            state_in = S_ISSUE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_ISSUE;
         slot_valid_ff <= '{default: 1'b0};
         link_valid_ff <= '{default: 1'b0};
         nfo_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         slot_valid_ff <= slot_valid_in;
         link_valid_ff <= link_valid_in;
         nfo_ff        <= nfo_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      link_idx_ff <= link_idx_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.status        = rsp_ff.status;
   assign rsp_ch.slot_index    = rsp_ff.slot_index;
   assign rsp_ch.found_payload = rsp_ff.found_payload;

endmodule

// ===== src/hash_table_overflow_area_core.sv =====
// Channel | Dir | Handshake   | Payload
// req_ch  | in  | valid/ready | op, record_key, record_payload
// rsp_ch  | out | valid/ready | status, slot_index, found_payload
//
// Each request passes through the back-end states S_ISSUE (slot RAM read)
// and S_EXEC (execute and write back); the back end takes a new request
// only in S_ISSUE, after the last one has been executed.
// Reset clears slot and link valid bits and the overflow fill pointer;
// slot RAM contents are not cleared, there is no clearing pass.
// A stalled response holds in its register; the back end then waits,
// the queue fills, the hash pipeline stops and req_ch.ready drops.
module hash_table_overflow_area_core
   import htoa_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   htoa_req_if.sink   req_ch,
   htoa_rsp_if.source rsp_ch
);

   // front -> queue
   logic         fq_valid, fq_ready;
   htoa_cmd_type fq_cmd;
   // queue -> back
   logic         qb_valid, qb_ready;
   htoa_cmd_type qb_cmd;

   // Front: accepts requests and computes the home slot (key mod
   // HOME_SLOTS) in two stages, multiply by reciprocal then back-multiply.
   htoa_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .out_valid (fq_valid),
      .out_ready (fq_ready),
      .out_cmd   (fq_cmd)
   );

   // Short queue decoupling the hash pipeline from the table engine.
   htoa_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_cmd    (fq_cmd),
      .out_valid (qb_valid),
      .out_ready (qb_ready),
      .out_cmd   (qb_cmd)
   );

   // Back: table engine with slot RAM, valid bits, links and the
   // overflow fill pointer, plus the response register.
   htoa_back u_back (
      .clock    (clock),
      .reset    (reset),
      .in_valid (qb_valid),
      .in_ready (qb_ready),
      .in_cmd   (qb_cmd),
      .rsp_ch   (rsp_ch)
   );

endmodule

// ===== src/htoa_checker.sv =====
`include "hash_table_overflow_area_core_assert.svh"

module htoa_checker
   import htoa_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [STATUS_W-1:0]   status,
   input logic [SLOT_IDX_W-1:0] slot_index,
   input logic [PAYLOAD_W-1:0]  found_payload
);

   logic rsp_stall;
   logic no_data;

   assign rsp_stall = rsp_valid && !rsp_ready;
   assign no_data   = (status == ST_INS_HOME) || (status == ST_INS_OVF)
                   || (status == ST_FULL) || (status == ST_MISS);

   `HTOA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(status) && $stable(slot_index) && $stable(found_payload), "stalled response changed")

   `HTOA_ASSERT_NOW(a_no_data_zero, clock, reset, rsp_valid && no_data, found_payload == '0, "payload nonzero on insert or miss")

   `HTOA_ASSERT_NOW(a_ovf_slot, clock, reset, rsp_valid && (status == ST_INS_OVF), slot_index >= SLOT_IDX_W'(HOME_SLOTS), "overflow insert reports a home slot")

   `HTOA_ASSERT_NEXT_LIVE(a_reset_quiet, clock, reset, !rsp_valid, "response valid right after reset")

endmodule

bind hash_table_overflow_area_core htoa_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .status        (rsp_ch.status),
   .slot_index    (rsp_ch.slot_index),
   .found_payload (rsp_ch.found_payload)
);

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import htoa_pkg::*;

   // Op code 3 has no name in the package; the core treats it as a search.
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};

   logic clock;
   logic reset;

   htoa_req_if req_if ();
   htoa_rsp_if rsp_if ();

   hash_table_overflow_area_core DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   // ------------------------------------------------------------------
   // Clock: 20 ns period.
   // ------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Shadow copy of the table. Keys and data are only read while the
   // matching used bit is set, links only while the link is valid.
   // ------------------------------------------------------------------
   bit                   tbl_used  [TOTAL_SLOTS];
   logic [KEY_W-1:0]     tbl_key   [TOTAL_SLOTS];
   logic [PAYLOAD_W-1:0] tbl_data  [TOTAL_SLOTS];
   bit                   chain_on  [HOME_SLOTS];
   int                   chain_ovf [HOME_SLOTS];
   int                   ovf_fill;

   // Responses still owed by the core, oldest first.
   htoa_rsp_type pending_outcomes[$];

   int  mismatches;
   bit  src_idle_on;
   bit  sink_stall_on;

   // One line per mismatch, counted.
   task automatic report_mismatch(input string what);
      mismatches++;
      $display("MISMATCH at %0t ns: %s", $time, what);
   endtask

   // Apply one request to the shadow table and return the response it owes.
   function automatic htoa_rsp_type apply_table_op(input logic [OP_W-1:0]      op,
                                                    input logic [KEY_W-1:0]     key,
                                                    input logic [PAYLOAD_W-1:0] data);
      int           home;
      int           spot;
      int           ovf;
      bit           hit;
      bit           hit_home;
      htoa_rsp_type res;

      home              = int'({1'b0, key} % 32'(HOME_SLOTS));
      res.status        = ST_MISS;
      res.slot_index    = SLOT_IDX_W'(home);
      res.found_payload = '0;

      if (op == OP_INSERT) begin
         if (!tbl_used[home]) begin
            tbl_used[home] = 1'b1;
            tbl_key[home]  = key;
            tbl_data[home] = data;
            chain_on[home] = 1'b0;        // fresh home entry drops any old link
            res.status     = ST_INS_HOME;
         end else if (ovf_fill < OVERFLOW_SLOTS) begin
            spot            = HOME_SLOTS + ovf_fill;
            tbl_used[spot]  = 1'b1;
            tbl_key[spot]   = key;
            tbl_data[spot]  = data;
            chain_on[home]  = 1'b1;       // relinks even if a link existed
            chain_ovf[home] = ovf_fill;
            ovf_fill++;                   // overflow slots are never handed back
            res.status      = ST_INS_OVF;
            res.slot_index  = SLOT_IDX_W'(spot);
         end else begin
            res.status = ST_FULL;
         end
         return res;
      end

      // Search, remove and the unused op: linked overflow entry first.
      hit      = 1'b0;
      hit_home = 1'b0;
      spot     = home;
      if (chain_on[home]) begin
         ovf = HOME_SLOTS + chain_ovf[home];
         if (tbl_used[ovf] && tbl_key[ovf] == key) begin
            hit  = 1'b1;
            spot = ovf;
         end
      end
      if (!hit && tbl_used[home] && tbl_key[home] == key) begin
         hit      = 1'b1;
         hit_home = 1'b1;
      end
      if (!hit)
         return res;

      res.slot_index    = SLOT_IDX_W'(spot);
      res.found_payload = tbl_data[spot];
      if (op == OP_REMOVE) begin
         tbl_used[spot] = 1'b0;
         if (hit_home)
            chain_on[home] = 1'b0;      // orphaned overflow entry stays behind
         res.status = ST_REMOVED;
      end else begin
         res.status = ST_FOUND;
      end
      return res;
   endfunction

   // Idle length: mostly zero or short, now and then long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 3);
      else if (r < 98)
         return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // ------------------------------------------------------------------
   // Request driver. Enters and leaves on a falling edge; valid stays high
   // between back-to-back requests so it is never lowered and raised in the
   // same step.
   // ------------------------------------------------------------------
   task automatic send_request(input logic [OP_W-1:0]      op,
                               input logic [KEY_W-1:0]     key,
                               input logic [PAYLOAD_W-1:0] data);
      int gap;
      gap = src_idle_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid          <= 1'b1;
      req_if.op             <= op;
      req_if.record_key     <= key;
      req_if.record_payload <= data;
      @(posedge clock);
      while (!req_if.ready)
         @(posedge clock);
      // Accepted on this edge.
      pending_outcomes.push_back(apply_table_op(op, key, data));
      @(negedge clock);
   endtask

   // ------------------------------------------------------------------
   // Response sink: random back-pressure while enabled.
   // ------------------------------------------------------------------
   initial begin : rsp_backpressure
      int stall_left;
      stall_left   = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (sink_stall_on && stall_left == 0 && $urandom_range(0, 99) < 25)
            stall_left = pick_gap();
         if (stall_left > 0) begin
            rsp_if.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------
   // Response checker: each accepted response against the oldest owed one.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      htoa_rsp_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_outcomes.size() == 0) begin
            report_mismatch($sformatf("unexpected response status=%0d slot=%0d",
                                      rsp_if.status, rsp_if.slot_index));
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_if.status !== want.status)
               report_mismatch($sformatf("status %0d, want %0d",
                                         rsp_if.status, want.status));
            if (rsp_if.slot_index !== want.slot_index)
               report_mismatch($sformatf("slot_index %0d, want %0d",
                                         rsp_if.slot_index, want.slot_index));
            if (rsp_if.found_payload !== want.found_payload)
               report_mismatch($sformatf("found_payload %h, want %h",
                                         rsp_if.found_payload, want.found_payload));
         end
      end
   end

   // ------------------------------------------------------------------
   // Directed tests. They build on each other's table contents.
   // Key KEY_MAX and keys 1, 8, 15 all hash to home slot 1; 6, 13, 20 to 6.
   // ------------------------------------------------------------------

   // Lookups on an empty table miss at the home slot.
   task automatic test_empty_table();
      send_request(OP_SEARCH, '0, '0);
      send_request(OP_REMOVE, KEY_MAX, '1);
      send_request(OP_SEARCH, 31'd6, '0);
   endtask

   // Plain home inserts, extreme key and payloads.
   task automatic test_home_insert();
      send_request(OP_INSERT, KEY_MAX, '1);
      send_request(OP_SEARCH, KEY_MAX, '0);
      send_request(OP_INSERT, 31'd6, 64'h8000_0000_0000_0001);
      send_request(OP_SEARCH, 31'd6, '0);
   endtask

   // Duplicate key into overflow, relink on a later collision, overflow
   // remove with a stale link, then the table-full drop.
   task automatic test_overflow_chain();
      send_request(OP_INSERT, KEY_MAX, 64'h0123_4567_89AB_CDEF);  // duplicate
      send_request(OP_SEARCH, KEY_MAX, '0);                       // overflow hit
      send_request(OP_INSERT, 31'd8, '0);                         // relink
      send_request(OP_SEARCH, KEY_MAX, '0);                       // old entry lost
      send_request(OP_SEARCH, 31'd8, '0);
      send_request(OP_REMOVE, 31'd8, '0);
      send_request(OP_SEARCH, 31'd8, '0);                         // stale link
      send_request(OP_INSERT, 31'd13, 64'hFFFF_0000_FFFF_0000);   // full
   endtask

   // Home remove clears the link; home slot reused afterwards.
   task automatic test_home_remove();
      send_request(OP_REMOVE, KEY_MAX, '0);
      send_request(OP_REMOVE, KEY_MAX, '0);
      send_request(OP_INSERT, 31'd1, 64'h5555_5555_5555_5555);
      send_request(OP_SEARCH, 31'd1, '0);
      send_request(OP_REMOVE, 31'd6, 64'hDEAD_BEEF_DEAD_BEEF);     // payload ignored
   endtask

   // Op 3 acts as a search.
   task automatic test_unused_op();
      send_request(OP_UNUSED, 31'd1, '0);
      send_request(OP_UNUSED, 31'd20, '1);
   endtask

   // Random traffic. Keys mostly from a small pool per home slot so that
   // inserts, hits and removes keep meeting; the rest spread over all bits or sit near KEY_MAX.
   task automatic test_random_traffic(input int count, input bit idle_src,
                                      input bit stall_sink);
      int                   r;
      logic [OP_W-1:0]      op;
      logic [KEY_W-1:0]     key;
      logic [PAYLOAD_W-1:0] data;
      src_idle_on   = idle_src;
      sink_stall_on = stall_sink;
      repeat (count) begin
         r = $urandom_range(0, 99);
         if (r < 40)
            op = OP_INSERT;
         else if (r < 75)
            op = OP_SEARCH;
         else if (r < 95)
            op = OP_REMOVE;
         else
            op = OP_UNUSED;

         r = $urandom_range(0, 99);
         if (r < 70)
            key = KEY_W'($urandom_range(0, HOME_SLOTS - 1) + HOME_SLOTS * $urandom_range(0, 3));
         else if (r < 85)
            key = KEY_W'($urandom);
         else
            key = KEY_MAX - KEY_W'($urandom_range(0, 20));

         r = $urandom_range(0, 19);
         if (r == 0)
            data = '0;
         else if (r == 1)
            data = '1;
         else
            data = {$urandom, $urandom};

         send_request(op, key, data);
      end
   endtask

   // ------------------------------------------------------------------
   // Main sequence.
   // ------------------------------------------------------------------
   initial begin
      mismatches            = 0;
      ovf_fill              = 0;
      src_idle_on           = 1'b1;
      sink_stall_on         = 1'b1;
      reset                 = 1'b1;
      req_if.valid          = 1'b0;
      req_if.op             = OP_INSERT;
      req_if.record_key     = '0;
      req_if.record_payload = '0;
      foreach (tbl_used[i])
         tbl_used[i] = 1'b0;
      foreach (chain_on[i]) begin
         chain_on[i]  = 1'b0;
         chain_ovf[i] = 0;
      end

      // Synchronous reset, released on a falling edge.
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_empty_table();
      test_home_insert();
      test_overflow_chain();
      test_home_remove();
      test_unused_op();

      // Random part in four flavors of idling.
      test_random_traffic(420, 1'b1, 1'b1);
      test_random_traffic(400, 1'b0, 1'b0);
      test_random_traffic(420, 1'b1, 1'b0);
      test_random_traffic(410, 1'b0, 1'b1);

      req_if.valid <= 1'b0;

      // Drain, then watch a while for stray responses.
      while (pending_outcomes.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);

      if (mismatches == 0) begin
         $display("hash_table_overflow_area_core test passed");
      end else begin
         $display("hash_table_overflow_area_core test failed");
      end
      $finish;
   end

   // Hard stop well beyond the slowest legal run.
   initial begin
      #30_000_000;
      $display("hash_table_overflow_area_core test failed");
      $finish;
   end

endmodule
